[hw/rtl/ebc_pkg.sv]
// Constants and helper functions for the epoch to BCD calendar unit.
package ebc_pkg;

  localparam logic [31:0] EPOCH_OFFSET  = 32'd946681200;
  localparam logic [17:0] DAYS_CENTURY  = 18'd36525;
  // Reciprocals for division by constants: x / 15, x / 15, x / 3, x / 1461, x / 7.
  localparam logic [30:0] RECIP_15_WIDE = 31'd1145324613; // shift 34, x < 2^30
  localparam logic [24:0] RECIP_15_NARR = 25'd17895698;   // shift 28, x < 19173961
  localparam logic [19:0] RECIP_3       = 20'd699051;     // shift 21, x < 2^19
  localparam logic [15:0] RECIP_1461    = 16'd45934;      // shift 26, x < 2^16
  localparam logic [17:0] RECIP_7       = 18'd149797;     // shift 20, x < 2^17
  localparam logic [10:0] DAYS_QUAD     = 11'd1461;
  // 2000-01-01 was a Saturday; weekday = (days + 6) mod 7, Sunday as 7.
  localparam logic [2:0]  WDAY_BASE     = 3'd6;

  // Day of year at which a month ends (exclusive), for months 1 to 11.
  function automatic logic [8:0] month_end(input logic [3:0] m, input logic leap);
    logic [8:0] e;
    unique case (m)
      4'd1:    e = 9'd31;
      4'd2:    e = 9'd59;
      4'd3:    e = 9'd90;
      4'd4:    e = 9'd120;
      4'd5:    e = 9'd151;
      4'd6:    e = 9'd181;
      4'd7:    e = 9'd212;
      4'd8:    e = 9'd243;
      4'd9:    e = 9'd273;
      4'd10:   e = 9'd304;
      4'd11:   e = 9'd334;
      default: e = 9'd0;
    endcase
    if (leap && m >= 4'd2 && m <= 4'd11) begin
      e = e + 9'd1;
    end
    return e;
  endfunction

  // Two BCD digits of a value below 100.
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [17:0] p;
    logic [3:0]  tens;
    logic [6:0]  ones;
    p    = 18'(v) * 18'd205;
    tens = p[14:11];
    ones = v - 7'(tens) * 7'd10;
    return {tens, ones[3:0]};
  endfunction

endpackage

[hw/rtl/epoch_to_bcd_calendar_unit.sv]
// Top level of the epoch seconds to BCD calendar converter.
//
// The unit converts a 32-bit seconds count since 1970 into the seven BCD time
// registers of a real-time clock, counted from 2000-01-01 00:00:00 in UTC+1.
// The input channel carries one count per beat on in_tdata. The result
// channel carries seconds, minutes, hours, weekday, day, month and year on
// out_tdata, and out_tuser flags a count before 2000 or after 2099, in which
// case every data field is zero.
// The work runs through a twelve-stage pipeline: the time of day is split
// off by three reciprocal multiplications, the day count is cut into
// four-year blocks, years and months by parallel compares against constant
// tables, and the last stage packs the BCD digits.
// A new beat may enter in every cycle while the pipeline is not stalled, so
// throughput is one item per cycle. The whole pipeline advances together;
// when the receiver holds out_tready low with a result waiting, every stage
// freezes and in_tready falls, so no item is lost or repeated. Empty stages
// still fill while the output stage is free.
// Reset (rst_n low at a clock edge) clears all valid bits; the pipeline is
// then empty and ready at once.
module epoch_to_bcd_calendar_unit
  import ebc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] epoch_seconds
  output logic        out_tvalid,
  input  logic        out_tready,
  // [6:0] seconds_bcd, [13:7] minutes_bcd, [19:14] hours_bcd, [22:20] weekday,
  // [28:23] day_bcd, [33:29] month_bcd, [41:34] year_bcd, [47:42] zero fill
  output logic [47:0] out_tdata,
  output logic        out_tuser   // [0] out_of_range
);

  logic [12:1] v_r;
  logic        en;

  assign en        = !v_r[12] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[11:1], in_tvalid};
    end
  end

  // Stage 1: remove offset.
  logic [31:0] rem1_r;
  logic        oor1_r;
  // Stage 2: seconds quotient product.
  logic [60:0] prod2_r;
  logic [31:0] rem2_r;
  logic        oor2_r;
  // Stage 3: minutes count and seconds.
  logic [26:0] q3_r;
  logic [5:0]  sec3_r;
  logic        oor3_r;
  // Stage 4.
  logic [49:0] prod4_r;
  logic [26:0] q4_r;
  logic [5:0]  sec4_r;
  logic        oor4_r;
  // Stage 5: hours count and minutes.
  logic [21:0] q5_r;
  logic [5:0]  sec5_r, min5_r;
  logic        oor5_r;
  // Stage 6.
  logic [38:0] prod6_r;
  logic [21:0] q6_r;
  logic [5:0]  sec6_r, min6_r;
  logic        oor6_r;
  // Stage 7: day count and hours.
  logic [17:0] d7_r;
  logic [5:0]  sec7_r, min7_r;
  logic [4:0]  hr7_r;
  logic        oor7_r;
  // Stage 8: four-year block and weekday products.
  logic [31:0] prod8a_r;
  logic [34:0] prod8b_r;
  logic [15:0] d8_r;
  logic [16:0] xw8_r;
  logic [5:0]  sec8_r, min8_r;
  logic [4:0]  hr8_r;
  logic        oor8_r;
  // Stage 9: block index, day in block, weekday.
  logic [4:0]  quad9_r;
  logic [10:0] r9_r;
  logic [2:0]  wd9_r;
  logic [5:0]  sec9_r, min9_r;
  logic [4:0]  hr9_r;
  logic        oor9_r;
  // Stage 10: year and day of year.
  logic [6:0]  year10_r;
  logic [8:0]  dy10_r;
  logic        leap10_r;
  logic [2:0]  wd10_r;
  logic [5:0]  sec10_r, min10_r;
  logic [4:0]  hr10_r;
  logic        oor10_r;
  // Stage 11: month.
  logic [3:0]  mon11_r;
  logic [6:0]  year11_r;
  logic [8:0]  dy11_r;
  logic        leap11_r;
  logic [2:0]  wd11_r;
  logic [5:0]  sec11_r, min11_r;
  logic [4:0]  hr11_r;
  logic        oor11_r;
  // Stage 12: output register.
  logic [41:0] res12_r;
  logic        oor12_r;

  // Combinational helpers between stages.
  logic [26:0] q3_nxt;
  logic [31:0] sec3_full;
  logic [21:0] q5_nxt;
  logic [26:0] min5_full;
  logic [17:0] d7_nxt;
  logic [21:0] hr7_full;
  logic [16:0] xw8_nxt;
  logic [4:0]  quad9_nxt;
  logic [10:0] r9_full;
  logic [14:0] wq9;
  logic [16:0] wr9_full;
  logic [2:0]  wd9_nxt;
  logic [1:0]  yq10;
  logic [8:0]  dy10_nxt;
  logic [3:0]  mon11_nxt;
  logic [8:0]  dom12;
  logic [41:0] res12_nxt;

  always_comb begin
    q3_nxt    = prod2_r[60:34];
    sec3_full = rem2_r - 32'(q3_nxt) * 32'd60;
    q5_nxt    = prod4_r[49:28];
    min5_full = q4_r - 27'(q5_nxt) * 27'd60;
    d7_nxt    = prod6_r[38:21];
    hr7_full  = q6_r - 22'(d7_nxt) * 22'd24;
    xw8_nxt   = 17'(d7_r[15:0]) + 17'(WDAY_BASE);
    quad9_nxt = prod8a_r[30:26];
    r9_full   = d8_r[10:0] - 11'(quad9_nxt) * DAYS_QUAD;
    wq9       = prod8b_r[34:20];
    wr9_full  = xw8_r - 17'(wq9) * 17'd7;
    wd9_nxt   = (wr9_full[2:0] == 3'd0) ? 3'd7 : wr9_full[2:0];

    priority if (r9_r < 11'd366) begin
      yq10 = 2'd0; dy10_nxt = r9_r[8:0];
    end else if (r9_r < 11'd731) begin
      yq10 = 2'd1; dy10_nxt = 9'(r9_r - 11'd366);
    end else if (r9_r < 11'd1096) begin
      yq10 = 2'd2; dy10_nxt = 9'(r9_r - 11'd731);
    end else begin
      yq10 = 2'd3; dy10_nxt = 9'(r9_r - 11'd1096);
    end

    mon11_nxt = 4'd1;
    for (int m = 1; m <= 11; m++) begin
      if (dy10_r >= month_end(4'(m), leap10_r)) begin
        mon11_nxt = mon11_nxt + 4'd1;
      end
    end

    dom12 = dy11_r - month_end(mon11_r - 4'd1, leap11_r) + 9'd1;
    res12_nxt = {to_bcd(year11_r),
                 5'(to_bcd({3'd0, mon11_r})),
                 6'(to_bcd(dom12[6:0])),
                 wd11_r,
                 6'(to_bcd({2'd0, hr11_r})),
                 7'(to_bcd({1'd0, min11_r})),
                 7'(to_bcd({1'd0, sec11_r}))};
    if (oor11_r) begin
      res12_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem1_r   <= in_tdata - EPOCH_OFFSET;
      oor1_r   <= in_tdata < EPOCH_OFFSET;

      prod2_r  <= 61'(rem1_r[31:2]) * 61'(RECIP_15_WIDE);
      rem2_r   <= rem1_r;
      oor2_r   <= oor1_r;

      q3_r     <= q3_nxt;
      sec3_r   <= sec3_full[5:0];
      oor3_r   <= oor2_r;

      prod4_r  <= 50'(q3_r[26:2]) * 50'(RECIP_15_NARR);
      q4_r     <= q3_r;
      sec4_r   <= sec3_r;
      oor4_r   <= oor3_r;

      q5_r     <= q5_nxt;
      sec5_r   <= sec4_r;
      min5_r   <= min5_full[5:0];
      oor5_r   <= oor4_r;

      prod6_r  <= 39'(q5_r[21:3]) * 39'(RECIP_3);
      q6_r     <= q5_r;
      sec6_r   <= sec5_r;
      min6_r   <= min5_r;
      oor6_r   <= oor5_r;

      d7_r     <= d7_nxt;
      sec7_r   <= sec6_r;
      min7_r   <= min6_r;
      hr7_r    <= hr7_full[4:0];
      oor7_r   <= oor6_r;

      prod8a_r <= 32'(d7_r[15:0]) * 32'(RECIP_1461);
      prod8b_r <= 35'(xw8_nxt) * 35'(RECIP_7);
      d8_r     <= d7_r[15:0];
      xw8_r    <= xw8_nxt;
      sec8_r   <= sec7_r;
      min8_r   <= min7_r;
      hr8_r    <= hr7_r;
      oor8_r   <= oor7_r || (d7_r >= DAYS_CENTURY);

      quad9_r  <= quad9_nxt;
      r9_r     <= r9_full;
      wd9_r    <= wd9_nxt;
      sec9_r   <= sec8_r;
      min9_r   <= min8_r;
      hr9_r    <= hr8_r;
      oor9_r   <= oor8_r;

      year10_r <= {quad9_r, 2'b00} + 7'(yq10);
      dy10_r   <= dy10_nxt;
      leap10_r <= (yq10 == 2'd0);
      wd10_r   <= wd9_r;
      sec10_r  <= sec9_r;
      min10_r  <= min9_r;
      hr10_r   <= hr9_r;
      oor10_r  <= oor9_r;

      mon11_r  <= mon11_nxt;
      year11_r <= year10_r;
      dy11_r   <= dy10_r;
      leap11_r <= leap10_r;
      wd11_r   <= wd10_r;
      sec11_r  <= sec10_r;
      min11_r  <= min10_r;
      hr11_r   <= hr10_r;
      oor11_r  <= oor10_r;

      res12_r  <= res12_nxt;
      oor12_r  <= oor11_r;
    end
  end

  assign out_tvalid = v_r[12];
  assign out_tdata  = {6'd0, res12_r};
  assign out_tuser  = oor12_r;

endmodule

[verif/tb_top.sv]
// Testbench for the epoch seconds to BCD calendar unit with a self-checking date predictor.
module tb_top
  import ebc_pkg::*;
();

  typedef struct packed {
    logic [7:0] year;
    logic [4:0] month;
    logic [5:0] day;
    logic [2:0] wday;
    logic [5:0] hours;
    logic [6:0] minutes;
    logic [6:0] seconds;
    logic       oor;
  } cal_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic        out_tuser;

  logic [31:0] pending_counts[$];
  cal_t        expected_dates[$];
  int          errors = 0;
  bit          calm = 1'b0;
  int          send_gap;
  int          recv_gap;
  int          offered_n = 0;
  int          accepted_n = 0;

  epoch_to_bcd_calendar_unit u_top (.*);

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic logic [7:0] bcd2(input int v);
    return 8'(((v / 10) % 10) * 16 + (v % 10));
  endfunction

  // Year- and month-stepping calendar conversion; all fields zero when out of range.
  function automatic cal_t calendar_of(input logic [31:0] secs);
    cal_t c;
    int unsigned rem;
    int unsigned days;
    int unsigned yr;
    int unsigned mon;
    int unsigned len;
    int unsigned y;
    int unsigned w;
    int unsigned leap;
    int mlen[12];
    int mkey[12];
    mlen = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    mkey = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
    c = '0;
    if (secs < EPOCH_OFFSET) begin
      c.oor = 1'b1;
      return c;
    end
    rem = secs - EPOCH_OFFSET;
    c.seconds = 7'(bcd2(rem % 60));
    rem = rem / 60;
    c.minutes = 7'(bcd2(rem % 60));
    rem = rem / 60;
    c.hours = 6'(bcd2(rem % 24));
    days = rem / 24;
    if (days >= 36525) begin
      c = '0;
      c.oor = 1'b1;
      return c;
    end
    leap = 1;
    for (yr = 0; yr < 100; yr++) begin
      leap = (yr % 4 == 0) ? 1 : 0;
      len = 365 + leap;
      if (days < len) break;
      days -= len;
    end
    for (mon = 1; mon < 12; mon++) begin
      len = mlen[mon - 1] + ((leap != 0 && mon == 2) ? 1 : 0);
      if (days < len) break;
      days -= len;
    end
    // Sakamoto's rule, with Sunday mapped to 7.
    y = yr + 2000 - ((mon < 3) ? 1 : 0);
    w = (y + y / 4 - y / 100 + y / 400 + mkey[mon - 1] + days + 1) % 7;
    c.wday = (w == 0) ? 3'd7 : 3'(w);
    c.day = 6'(bcd2(days + 1));
    c.month = 5'(bcd2(mon));
    c.year = bcd2(yr);
    return c;
  endfunction

  // Driver: offers the head of the queue, with random idle bursts. A beat
  // stays on the bus until the monitor has counted it as accepted.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      send_gap  <= 0;
    end else if (in_tvalid && accepted_n != offered_n) begin
      // Hold the beat until it is taken.
    end else if (send_gap > 0) begin
      in_tvalid <= 1'b0;
      send_gap  <= send_gap - 1;
    end else if (pending_counts.size() > 0 && (calm || $urandom_range(9) != 0)) begin
      in_tvalid <= 1'b1;
      in_tdata  <= pending_counts[0];
      offered_n <= offered_n + 1;
    end else begin
      in_tvalid <= 1'b0;
      if (!calm && pending_counts.size() > 0) send_gap <= $urandom_range(12, 1);
    end
  end

  // Receiver backpressure in bursts as well.
  always @(negedge clk) begin
    if (calm || !rst_n) begin
      out_tready <= 1'b1;
      recv_gap   <= 0;
    end else if (recv_gap > 0) begin
      out_tready <= 1'b0;
      recv_gap   <= recv_gap - 1;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(9) == 0) recv_gap <= $urandom_range(12, 1);
    end
  end

  // Monitor: the accepted input beat is predicted, the output beat is checked.
  always @(posedge clk) begin
    cal_t got;
    cal_t want;
    if (rst_n && in_tvalid && in_tready) begin
      expected_dates.push_back(calendar_of(in_tdata));
      void'(pending_counts.pop_front());
      accepted_n++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got = '{year: out_tdata[41:34], month: out_tdata[33:29], day: out_tdata[28:23],
              wday: out_tdata[22:20], hours: out_tdata[19:14],
              minutes: out_tdata[13:7], seconds: out_tdata[6:0], oor: out_tuser};
      if (expected_dates.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, actual %h", $time, got);
      end else begin
        want = expected_dates.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch, expected %h actual %h", $time, want, got);
        end
      end
    end
  end

  task automatic add_count(input logic [31:0] v);
    pending_counts.push_back(v);
  endtask

  // Random count within a day of a given day number since 2000.
  function automatic logic [31:0] count_on_day(input int unsigned d);
    return EPOCH_OFFSET + d * 86400 + $urandom_range(86399);
  endfunction

  task automatic wait_drained();
    while (pending_counts.size() > 0 || expected_dates.size() > 0) @(posedge clk);
  endtask

  initial begin
    int unsigned k;
    int unsigned leapdays[4];
    leapdays = '{59, 1520, 36219, 366};
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // Directed: range edges, leap days, month ends, extremes of the input.
    add_count(32'd0);
    add_count(32'hFFFF_FFFF);
    add_count(EPOCH_OFFSET - 1);
    add_count(EPOCH_OFFSET);
    add_count(EPOCH_OFFSET + 36525 * 86400 - 1);
    add_count(EPOCH_OFFSET + 36525 * 86400);
    add_count(EPOCH_OFFSET + 59 * 86400);
    add_count(EPOCH_OFFSET + 60 * 86400 - 1);
    add_count(EPOCH_OFFSET + 365 * 86400);
    add_count(EPOCH_OFFSET + 366 * 86400);
    add_count(EPOCH_OFFSET + 424 * 86400 + 86399);
    add_count(EPOCH_OFFSET + 36524 * 86400);
    add_count(32'hAAAA_AAAA);
    add_count(32'h5555_5555);
    for (k = 0; k < 4; k++) add_count(count_on_day(leapdays[k]));
    wait_drained();

    // Random: mostly within the century, some on either side.
    for (k = 0; k < 600; k++) begin
      case ($urandom_range(9))
        0: add_count($urandom());
        1: add_count($urandom_range(EPOCH_OFFSET - 1));
        2: add_count(EPOCH_OFFSET + 36525 * 86400 + $urandom_range(1000000));
        default: add_count(count_on_day($urandom_range(36524)));
      endcase
    end
    wait_drained();
    for (k = 0; k < 450; k++) add_count(count_on_day($urandom_range(36524)));
    wait_drained();
    calm = 1;
    for (k = 0; k < 200; k++) add_count($urandom());
    wait_drained();
    repeat (40) @(posedge clk);
    if (errors == 0 && expected_dates.size() == 0)
      $display("epoch_to_bcd_calendar_unit test passed");
    else
      $display("epoch_to_bcd_calendar_unit test failed");
    $finish;
  end

  initial begin
    #6000000;
    $display("epoch_to_bcd_calendar_unit test failed");
    $finish;
  end

endmodule
